### rtl/scdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scdp_pkg;

  localparam int SUBQUEUES = 8;
  localparam longint DEVICE_SECTORS = 51584;
  localparam int COUNT_BITS = 16;

  localparam int SQ_W = (SUBQUEUES > 1) ? $clog2(SUBQUEUES) : 1;
  localparam int CLASSES = 4;
  localparam int CLS_W = 2;
  localparam longint SPAN_RAW = DEVICE_SECTORS / SUBQUEUES;
  localparam longint SPAN = (SPAN_RAW == 0) ? 1 : SPAN_RAW;

  localparam int STARVE_W = 16;
  localparam int LIMIT_W = 8;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4);

  localparam int ADDR_W = 3;
  localparam logic REG_WRITE_STARVE_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    FLAG_ZERO,
    FLAG_END,
    FLAG_PROC,
    FLAG_PEND
  } flag_t;

  typedef enum logic [1:0] {
    STATUS_ADDED,
    STATUS_DISPATCHED,
    STATUS_EMPTY,
    STATUS_FULL
  } status_t;

  typedef enum logic {
    OP_ADD,
    OP_DISPATCH
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    flag_t                 flag;
  } entry_t;

  typedef entry_t [SUBQUEUES-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  // The subqueue is the number of span boundaries at or below the sector, capped at the last.
  function automatic logic [SQ_W-1:0] map_subqueue(input logic [31:0] sector);
    logic [SQ_W-1:0] q;
    q = '0;
    for (int k = 1; k < SUBQUEUES; k++) begin
      if ({32'd0, sector} >= 64'(longint'(k) * SPAN)) begin
        q = SQ_W'(k);
      end
    end
    return q;
  endfunction

endpackage

`default_nettype wire

### rtl/scdp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface scdp_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic        is_sync;
  logic        is_write;
  logic [31:0] sector;

  modport source (output valid, opcode, is_sync, is_write, sector, input ready);
  modport sink (input valid, opcode, is_sync, is_write, sector, output ready);
endinterface

interface scdp_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       chosen_sync;
  logic       chosen_write;
  logic [2:0] chosen_subqueue;

  modport source (output valid, status, chosen_sync, chosen_write, chosen_subqueue,
                  input ready);
  modport sink (input valid, status, chosen_sync, chosen_write, chosen_subqueue,
                output ready);
endinterface

`default_nettype wire

### rtl/scdp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module scdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/subqueue_conflict_dispatch_picker.sv
`timescale 1ns / 1ps
`default_nettype none
// Operation: an accepted word's first row read is issued to the state memory as it is taken. An
// add word's row is evaluated once and its result is registered. A dispatch word's evaluation
// takes one class row per step from the state memory, and up to four rows are read. The result
// is held until the output register is free. A new word is taken only in the idle state, after
// the last result has gone to the output register, so words do not overlap in the block.
// Reset (rst, synchronous): every count reads zero and every flag ZERO through per-row valid
// bits, so no clearing pass is run; starvation counter zero, write_starve_limit 4.

module subqueue_conflict_dispatch_picker (
  input  logic                         clk,
  input  logic                         rst,
  scdp_req_if.sink                     req,
  scdp_rsp_if.source                   rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [scdp_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import scdp_pkg::*;

  // Control state.
  state_t               state;
  state_t               state_next;
  logic [CLASSES-1:0]   row_valid;
  logic [STARVE_W-1:0]  starve;
  logic [STARVE_W-1:0]  starve_next;
  logic [LIMIT_W-1:0]   limit;
  logic                 out_valid;
  logic [1:0]           try_idx;

  // Per-word context captured at acceptance; rd_cls follows each row read.
  opcode_t              op_q;
  logic                 add_sync;
  logic                 add_write;
  logic [SQ_W-1:0]      add_q;
  logic                 prefer_wr;
  logic [CLS_W-1:0]     rd_cls;

  // Result waiting for the output register.
  status_t              res_status;
  logic                 res_sync;
  logic                 res_write;
  logic [SQ_W-1:0]      res_sq;

  // The result of the final evaluation cycle is held until the output register is free.
  status_t              res_status_q;
  logic                 res_sync_q;
  logic                 res_write_q;
  logic [SQ_W-1:0]      res_sq_q;

  // Memory port.
  logic                 mem_re;
  logic [CLS_W-1:0]     mem_raddr;
  logic [ROW_W-1:0]     mem_rdata;
  logic                 mem_we;
  row_t                 mem_wrow;

  logic                 accept;
  logic                 pref_now;
  logic                 load_out;
  logic                 cfg_write;
  logic [1:0]           try_inc;

  // Row evaluation.
  row_t                 row_rd;
  row_t                 row_disp;
  row_t                 row_add;
  logic                 add_full;
  logic                 busy;
  logic                 first_hit;
  logic [SQ_W-1:0]      first_idx;
  logic                 pend_hit;
  logic [SQ_W-1:0]      pend_idx;
  logic                 disp_hit;
  logic [SQ_W-1:0]      pick;
  logic [COUNT_BITS-1:0] pick_cnt;
  logic                 any_pend;
  logic                 last_try;

  // The state memory: one row per class, each row all subqueue entries of that class.
  scdp_ram #(
    .WIDTH (ROW_W),
    .DEPTH (CLASSES)
  ) u_state_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (rd_cls),
    .wdata (mem_wrow),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign accept   = req.valid && req.ready;
  assign pref_now = starve > STARVE_W'(limit);
  assign load_out = (state == ST_DONE) && (!out_valid || rsp.ready);
  assign last_try = (try_idx == 2'd3);
  assign try_inc  = try_idx + 2'd1;

  // A row never written since reset reads as all counts zero and all flags ZERO.
  assign row_rd = row_valid[rd_cls] ? row_t'(mem_rdata) : '0;

  // Add: bump the mapped entry's count and mark it PEND, unless its count is saturated.
  always_comb begin
    row_add  = row_rd;
    add_full = (row_rd[add_q].count == {COUNT_BITS{1'b1}});
    if (!add_full) begin
      row_add[add_q].count = row_rd[add_q].count + COUNT_BITS'(1);
      row_add[add_q].flag  = FLAG_PEND;
    end
  end

  // Dispatch search within the class row. Reads prefer a non-empty entry that is not PEND,
  // writes prefer a PROC entry; both fall back to the first PEND entry.
  always_comb begin
    busy      = 1'b0;
    first_hit = 1'b0;
    first_idx = '0;
    pend_hit  = 1'b0;
    pend_idx  = '0;
    for (int i = SUBQUEUES - 1; i >= 0; i--) begin
      if (row_rd[i].count != '0) begin
        busy = 1'b1;
      end
      if (rd_cls[0] ? (row_rd[i].flag == FLAG_PROC)
                    : (row_rd[i].count != '0 && row_rd[i].flag != FLAG_PEND)) begin
        first_hit = 1'b1;
        first_idx = SQ_W'(i);
      end
      if (row_rd[i].flag == FLAG_PEND) begin
        pend_hit = 1'b1;
        pend_idx = SQ_W'(i);
      end
    end
    disp_hit = busy && (first_hit || pend_hit);
    pick     = first_hit ? first_idx : pend_idx;
  end

  // Retire one request from the picked entry, then re-arm the class when nothing is PEND.
  always_comb begin
    row_disp = row_rd;
    pick_cnt = row_rd[pick].count;
    if (pick_cnt != '0) begin
      pick_cnt = pick_cnt - COUNT_BITS'(1);
    end
    row_disp[pick].count = pick_cnt;
    if (pick_cnt == '0) begin
      row_disp[pick].flag = FLAG_ZERO;
    end else if (rd_cls[0]) begin
      row_disp[pick].flag = FLAG_PROC;
    end else begin
      row_disp[pick].flag = FLAG_END;
    end
    any_pend = 1'b0;
    for (int i = 0; i < SUBQUEUES; i++) begin
      if (row_disp[i].flag == FLAG_PEND) begin
        any_pend = 1'b1;
      end
    end
    if (!any_pend) begin
      for (int i = 0; i < SUBQUEUES; i++) begin
        if (row_disp[i].count != '0) begin
          row_disp[i].flag = FLAG_PEND;
        end
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (op_q == OP_ADD || disp_hit || last_try) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs, memory port and result of the evaluation cycle.
  // Class search order: preferred direction async then sync, then the other direction.
  always_comb begin
    req.ready   = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    mem_we      = 1'b0;
    mem_wrow    = row_disp;
    starve_next = starve;
    res_status  = STATUS_EMPTY;
    res_sync    = 1'b0;
    res_write   = 1'b0;
    res_sq      = '0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        mem_re    = req.valid;
        if (opcode_t'(req.opcode) == OP_ADD) begin
          mem_raddr = {req.is_sync, req.is_write};
        end else begin
          mem_raddr = {1'b0, pref_now};
        end
      end
      ST_EVAL: begin
        if (op_q == OP_ADD) begin
          mem_we     = !add_full;
          mem_wrow   = row_add;
          res_status = add_full ? STATUS_FULL : STATUS_ADDED;
          res_sync   = add_sync;
          res_write  = add_write;
          res_sq     = add_q;
        end else if (disp_hit) begin
          mem_we     = 1'b1;
          res_status = STATUS_DISPATCHED;
          res_sync   = rd_cls[1];
          res_write  = rd_cls[0];
          res_sq     = pick;
          if (rd_cls[0]) begin
            starve_next = '0;
          end else if (starve != {STARVE_W{1'b1}}) begin
            starve_next = starve + STARVE_W'(1);
          end
        end else if (!last_try) begin
          mem_re    = 1'b1;
          mem_raddr = {try_inc[0], prefer_wr ^ try_inc[1]};
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Configuration port: one register, written in the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[ADDR_W-1] == REG_WRITE_STARVE_LIMIT) ? {24'd0, limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_valid <= '0;
      starve    <= '0;
      limit     <= LIMIT_RESET;
      out_valid <= 1'b0;
      try_idx   <= '0;
    end else begin
      state  <= state_next;
      starve <= starve_next;
      if (mem_we) begin
        row_valid[rd_cls] <= 1'b1;
      end
      if (cfg_write && paddr[ADDR_W-1] == REG_WRITE_STARVE_LIMIT) begin
        limit <= pwdata[LIMIT_W-1:0];
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        try_idx <= '0;
      end else if (state == ST_EVAL && mem_re) begin
        try_idx <= try_inc;
      end
    end
  end

  // Word context and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= opcode_t'(req.opcode);
      add_sync  <= req.is_sync;
      add_write <= req.is_write;
      add_q     <= map_subqueue(req.sector);
      prefer_wr <= pref_now;
    end
    if (mem_re) begin
      rd_cls <= mem_raddr;
    end
    if (load_out) begin
      rsp.status          <= res_status_q;
      rsp.chosen_sync     <= res_sync_q;
      rsp.chosen_write    <= res_write_q;
      rsp.chosen_subqueue <= 3'(res_sq_q);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EVAL) begin
      res_status_q <= res_status;
      res_sync_q   <= res_sync;
      res_write_q  <= res_write;
      res_sq_q     <= res_sq;
    end
  end

  assign rsp.valid = out_valid;

  // A new result only appears after the result-holding state.
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside the result-holding state");

  // State rows are only written back during evaluation.
  a_write_in_eval: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == ST_EVAL)
    else $error("state memory written outside evaluation");

  // A written row is valid from then on.
  a_row_valid: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> row_valid[$past(rd_cls)])
    else $error("written row not marked valid");

  // No new row read is issued while a result waits.
  a_no_read_in_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |-> !mem_re)
    else $error("state memory read while a result waits");

endmodule

`default_nettype wire
